[hdl/mivu_pkg.sv]
// ============================================================================
// mivu_pkg
// Shared types and constants for the minimum image vector unit.
// ============================================================================
`default_nettype none
package mivu_pkg;

    localparam int unsigned NUM_REGS   = 7;
    localparam int unsigned ADDR_WIDTH = 6;
    localparam int unsigned DATA_WIDTH = 64;

    localparam logic [2:0] REG_BOX_MODE   = 3'd0;
    localparam logic [2:0] REG_CELL_XX_YY = 3'd1;
    localparam logic [2:0] REG_CELL_ZZ_XY = 3'd2;
    localparam logic [2:0] REG_CELL_XZ_YZ = 3'd3;
    localparam logic [2:0] REG_INV_XX_YY  = 3'd4;
    localparam logic [2:0] REG_INV_ZZ_XY  = 3'd5;
    localparam logic [2:0] REG_INV_XZ_YZ  = 3'd6;

    localparam logic [2:0] MODE_NONE      = 3'd0;
    localparam logic [2:0] MODE_CUBIC     = 3'd1;
    localparam logic [2:0] MODE_ORTHO     = 3'd2;
    localparam logic [2:0] MODE_MONO_A    = 3'd3;
    localparam logic [2:0] MODE_MONO_B    = 3'd4;
    localparam logic [2:0] MODE_MONO_G    = 3'd5;
    localparam logic [2:0] MODE_TRICLINIC = 3'd6;

    // fractional wrap limits, Q.24
    localparam logic signed [63:0] FRAC_HALF = 64'sd8388608;
    localparam logic signed [63:0] FRAC_ONE  = 64'sd16777216;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [2:0]  box_mode;
        logic [63:0] cell_xx_yy;
        logic [63:0] cell_zz_xy;
        logic [63:0] cell_xz_yz;
        logic [63:0] inv_xx_yy;
        logic [63:0] inv_zz_xy;
        logic [63:0] inv_xz_yz;
    } cfg_t;

    typedef struct packed {
        logic periodic;
        logic cubic;
        logic use_xy;
        logic use_xz;
        logic use_yz;
    } mode_flags_t;

    function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
        logic signed [63:0] r;
        if (v > 128'(S64_MAX))
            r = S64_MAX;
        else if (v < 128'(S64_MIN))
            r = S64_MIN;
        else
            r = v[63:0];
        return r;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [127:0] s;
        s = 128'(a) + 128'(b);
        return sat64(s);
    endfunction

endpackage
`default_nettype wire

[hdl/mivu_cfg.sv]
// ============================================================================
// mivu_cfg
// Register file behind the configuration port.
// ============================================================================
`default_nettype none
module mivu_cfg
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mivu_pkg::ADDR_WIDTH-1:0]     paddr,
    input  wire logic [mivu_pkg::DATA_WIDTH-1:0]     pwdata,
    output logic      [mivu_pkg::DATA_WIDTH-1:0]     prdata,
    output logic                                     pready,
    output mivu_pkg::cfg_t                           cfg
);

    mivu_pkg::cfg_t cfg_reg;
    mivu_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     idx;

    assign pready = 1'b1;
    assign idx    = paddr[5:3];
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                mivu_pkg::REG_BOX_MODE:   cfg_next.box_mode   = pwdata[2:0];
                mivu_pkg::REG_CELL_XX_YY: cfg_next.cell_xx_yy = pwdata;
                mivu_pkg::REG_CELL_ZZ_XY: cfg_next.cell_zz_xy = pwdata;
                mivu_pkg::REG_CELL_XZ_YZ: cfg_next.cell_xz_yz = pwdata;
                mivu_pkg::REG_INV_XX_YY:  cfg_next.inv_xx_yy  = pwdata;
                mivu_pkg::REG_INV_ZZ_XY:  cfg_next.inv_zz_xy  = pwdata;
                mivu_pkg::REG_INV_XZ_YZ:  cfg_next.inv_xz_yz  = pwdata;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    always_comb
    begin
        case (idx)
            mivu_pkg::REG_BOX_MODE:   prdata = {61'd0, cfg_reg.box_mode};
            mivu_pkg::REG_CELL_XX_YY: prdata = cfg_reg.cell_xx_yy;
            mivu_pkg::REG_CELL_ZZ_XY: prdata = cfg_reg.cell_zz_xy;
            mivu_pkg::REG_CELL_XZ_YZ: prdata = cfg_reg.cell_xz_yz;
            mivu_pkg::REG_INV_XX_YY:  prdata = cfg_reg.inv_xx_yy;
            mivu_pkg::REG_INV_ZZ_XY:  prdata = cfg_reg.inv_zz_xy;
            mivu_pkg::REG_INV_XZ_YZ:  prdata = cfg_reg.inv_xz_yz;
            default:                  prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[hdl/mivu_queue.sv]
// ============================================================================
// mivu_queue
// Small register queue between the front and back parts.
// ============================================================================
`default_nettype none
module mivu_queue
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue pop while empty");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count did not advance on push");

endmodule
`default_nettype wire

[hdl/mivu_front.sv]
// ============================================================================
// mivu_front
// Accepts point pairs, forms the raw difference and decodes the box mode.
// ============================================================================
`default_nettype none
module mivu_front
#(
    parameter int unsigned COORD_WIDTH = 32
)
(
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [6*COORD_WIDTH-1:0]     in_coords,
    input  wire logic [2:0]                   box_mode,
    input  wire logic                         q_full,
    output logic                              q_push,
    output logic signed [COORD_WIDTH-1:0]     p1 [3],
    output logic signed [COORD_WIDTH:0]       d [3],
    output mivu_pkg::mode_flags_t             flags
);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p1[i] = in_coords[i*COORD_WIDTH +: COORD_WIDTH];
            d[i]  = (COORD_WIDTH+1)'($signed(in_coords[(i+3)*COORD_WIDTH +: COORD_WIDTH]))
                  - (COORD_WIDTH+1)'(p1[i]);
        end
    end

    always_comb
    begin
        flags = '0;
        case (box_mode)
            mivu_pkg::MODE_CUBIC:     flags = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
            mivu_pkg::MODE_ORTHO:     flags = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
            mivu_pkg::MODE_MONO_A:    flags = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
            mivu_pkg::MODE_MONO_B:    flags = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
            mivu_pkg::MODE_MONO_G:    flags = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
            mivu_pkg::MODE_TRICLINIC: flags = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
            default:                  flags = '0;
        endcase
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

endmodule
`default_nettype wire

[hdl/mivu_back.sv]
// ============================================================================
// mivu_back
// Seven-stage arithmetic pipeline: inverse transform, wrap, cell transform,
// saturation, image and squared length.
// ============================================================================
`default_nettype none
module mivu_back
#(
    parameter int unsigned COORD_WIDTH = 32
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mivu_pkg::cfg_t               cfg,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] in_p1 [3],
    input  wire logic signed [COORD_WIDTH:0]   in_d [3],
    input  wire mivu_pkg::mode_flags_t        in_flags,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_WIDTH-1:0]     sep [3],
    output logic        [63:0]                dist_sq,
    output logic signed [COORD_WIDTH-1:0]     image [3]
);

    localparam int unsigned CWD = COORD_WIDTH;
    localparam int unsigned DW  = COORD_WIDTH + 1;
    localparam logic signed [64:0] C_MAX = 65'((65'sd1 <<< (CWD - 1)) - 65'sd1);
    localparam logic signed [64:0] C_MIN = -C_MAX - 65'sd1;

    function automatic logic signed [CWD-1:0] satc(input logic signed [64:0] v);
        logic signed [CWD-1:0] r;
        if (v > C_MAX)
            r = C_MAX[CWD-1:0];
        else if (v < C_MIN)
            r = C_MIN[CWD-1:0];
        else
            r = v[CWD-1:0];
        return r;
    endfunction

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;

    assign en       = !v7_reg || out_ready;
    assign in_ready = en;

    // stage 1: inverse products
    logic signed [31:0]      ic [6];
    logic signed [DW-1:0]    iop [6];
    logic signed [63:0]      t1_next [6];
    logic signed [63:0]      t1_reg [6];
    logic signed [CWD-1:0]   p1_1_reg [3];
    logic signed [DW-1:0]    d1_reg [3];
    mivu_pkg::mode_flags_t   fl1_reg;

    always_comb
    begin
        ic[0] = cfg.inv_xx_yy[31:0];
        ic[1] = in_flags.cubic ? cfg.inv_xx_yy[31:0] : cfg.inv_xx_yy[63:32];
        ic[2] = in_flags.cubic ? cfg.inv_xx_yy[31:0] : cfg.inv_zz_xy[31:0];
        ic[3] = in_flags.use_xy ? cfg.inv_zz_xy[63:32] : 32'sd0;
        ic[4] = in_flags.use_xz ? cfg.inv_xz_yz[31:0] : 32'sd0;
        ic[5] = in_flags.use_yz ? cfg.inv_xz_yz[63:32] : 32'sd0;
        iop[0] = in_d[0];
        iop[1] = in_d[1];
        iop[2] = in_d[2];
        iop[3] = in_d[1];
        iop[4] = in_d[2];
        iop[5] = in_d[2];
        for (int k = 0; k < 6; k++)
            t1_next[k] = mivu_pkg::sat64((128'(iop[k]) * 128'(ic[k])) >>> 16);
    end

    // stage 2: row sums and wrap
    logic signed [63:0]      f_next [3];
    logic signed [63:0]      f_reg [3];
    logic signed [CWD-1:0]   p1_2_reg [3];
    logic signed [DW-1:0]    d2_reg [3];
    mivu_pkg::mode_flags_t   fl2_reg;

    always_comb
    begin
        logic signed [63:0] r [3];
        r[0] = mivu_pkg::sat_add64(mivu_pkg::sat_add64(t1_reg[0], t1_reg[3]), t1_reg[4]);
        r[1] = mivu_pkg::sat_add64(t1_reg[1], t1_reg[5]);
        r[2] = t1_reg[2];
        for (int i = 0; i < 3; i++)
        begin
            if (r[i] < -mivu_pkg::FRAC_HALF)
                f_next[i] = r[i] + mivu_pkg::FRAC_ONE;
            else if (r[i] > mivu_pkg::FRAC_HALF)
                f_next[i] = r[i] - mivu_pkg::FRAC_ONE;
            else
                f_next[i] = r[i];
        end
    end

    // stage 3: cell partial products
    logic signed [31:0]      cc [6];
    logic signed [63:0]      fop [6];
    logic signed [63:0]      ph_next [6];
    logic signed [64:0]      pl_next [6];
    logic signed [63:0]      ph_reg [6];
    logic signed [64:0]      pl_reg [6];
    logic signed [CWD-1:0]   p1_3_reg [3];
    logic signed [DW-1:0]    d3_reg [3];
    mivu_pkg::mode_flags_t   fl3_reg;

    always_comb
    begin
        cc[0] = cfg.cell_xx_yy[31:0];
        cc[1] = fl2_reg.cubic ? cfg.cell_xx_yy[31:0] : cfg.cell_xx_yy[63:32];
        cc[2] = fl2_reg.cubic ? cfg.cell_xx_yy[31:0] : cfg.cell_zz_xy[31:0];
        cc[3] = fl2_reg.use_xy ? cfg.cell_zz_xy[63:32] : 32'sd0;
        cc[4] = fl2_reg.use_xz ? cfg.cell_xz_yz[31:0] : 32'sd0;
        cc[5] = fl2_reg.use_yz ? cfg.cell_xz_yz[63:32] : 32'sd0;
        fop[0] = f_reg[0];
        fop[1] = f_reg[1];
        fop[2] = f_reg[2];
        fop[3] = f_reg[1];
        fop[4] = f_reg[2];
        fop[5] = f_reg[2];
        for (int k = 0; k < 6; k++)
        begin
            ph_next[k] = 64'($signed(fop[k][63:32])) * 64'(cc[k]);
            pl_next[k] = $signed({33'd0, fop[k][31:0]}) * 65'(cc[k]);
        end
    end

    // stage 4: combine, shift and saturate
    logic signed [63:0]      t4_next [6];
    logic signed [63:0]      t4_reg [6];
    logic signed [CWD-1:0]   p1_4_reg [3];
    logic signed [DW-1:0]    d4_reg [3];
    mivu_pkg::mode_flags_t   fl4_reg;

    always_comb
    begin
        for (int k = 0; k < 6; k++)
            t4_next[k] = mivu_pkg::sat64(((128'(ph_reg[k]) <<< 32) + 128'(pl_reg[k])) >>> 24);
    end

    // stage 5: separation
    logic signed [CWD-1:0]   s_next [3];
    logic signed [CWD-1:0]   s5_reg [3];
    logic signed [CWD-1:0]   p1_5_reg [3];

    always_comb
    begin
        logic signed [63:0] r [3];
        r[0] = mivu_pkg::sat_add64(mivu_pkg::sat_add64(t4_reg[0], t4_reg[3]), t4_reg[4]);
        r[1] = mivu_pkg::sat_add64(t4_reg[1], t4_reg[5]);
        r[2] = t4_reg[2];
        for (int i = 0; i < 3; i++)
            s_next[i] = fl4_reg.periodic ? satc(65'(r[i])) : satc(65'(d4_reg[i]));
    end

    // stage 6: image and squares
    logic signed [CWD-1:0]   img_next [3];
    logic        [63:0]      sq_next [3];
    logic        [2:0]       big_next;
    logic signed [CWD-1:0]   img6_reg [3];
    logic        [63:0]      sq6_reg [3];
    logic        [2:0]       big6_reg;
    logic signed [CWD-1:0]   s6_reg [3];

    always_comb
    begin
        logic [CWD-1:0] mag;
        logic [64:0]    mag_w;
        logic [31:0]    m32;
        for (int i = 0; i < 3; i++)
        begin
            img_next[i] = satc(65'(p1_5_reg[i]) + 65'(s5_reg[i]));
            mag         = s5_reg[i][CWD-1] ? CWD'(-s5_reg[i]) : CWD'(s5_reg[i]);
            mag_w       = 65'(mag);
            big_next[i] = (mag_w >> 32) != 65'd0;
            m32         = mag_w[31:0];
            sq_next[i]  = 64'(m32) * 64'(m32);
        end
    end

    // stage 7: squared length, output register
    logic [65:0] dsum;
    logic [63:0] dist_next;

    always_comb
    begin
        dsum = 66'(sq6_reg[0]) + 66'(sq6_reg[1]) + 66'(sq6_reg[2]);
        if ((big6_reg != 3'd0) || (dsum[65:64] != 2'd0))
            dist_next = '1;
        else
            dist_next = dsum[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg   <= t1_next;
            p1_1_reg <= in_p1;
            d1_reg   <= in_d;
            fl1_reg  <= in_flags;
            f_reg    <= f_next;
            p1_2_reg <= p1_1_reg;
            d2_reg   <= d1_reg;
            fl2_reg  <= fl1_reg;
            ph_reg   <= ph_next;
            pl_reg   <= pl_next;
            p1_3_reg <= p1_2_reg;
            d3_reg   <= d2_reg;
            fl3_reg  <= fl2_reg;
            t4_reg   <= t4_next;
            p1_4_reg <= p1_3_reg;
            d4_reg   <= d3_reg;
            fl4_reg  <= fl3_reg;
            s5_reg   <= s_next;
            p1_5_reg <= p1_4_reg;
            img6_reg <= img_next;
            sq6_reg  <= sq_next;
            big6_reg <= big_next;
            s6_reg   <= s5_reg;
            sep      <= s6_reg;
            image    <= img6_reg;
            dist_sq  <= dist_next;
        end
    end

    assign out_valid = v7_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(v6_reg) && $stable(v1_reg)))
        else $error("pipeline moved while stalled");
    a_take_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (en && in_valid) |=> v1_reg)
        else $error("accepted item lost at stage one");
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(dist_sq)))
        else $error("result changed while waiting");

endmodule
`default_nettype wire

[hdl/minimum_image_vector_unit.sv]
// ============================================================================
// minimum_image_vector_unit
// Minimum-image separation, squared distance and nearest image of a point pair.
// ============================================================================
// Takes one point pair per cycle while the queue is not full and returns one
// result per pair, in order. A pair passes through a four-entry queue and a
// seven-stage back pipeline. The rate is set by the back pipeline, which
// advances whenever its output register is empty or being taken. Box mode
// and cell registers must be written by the user over the register port
// only while no pair is in flight; the block itself does not enforce this.
`default_nettype none
module minimum_image_vector_unit
#(
    parameter int unsigned COORD_WIDTH = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic                                       psel,
    input  wire logic                                       penable,
    input  wire logic                                       pwrite,
    input  wire logic [mivu_pkg::ADDR_WIDTH-1:0]            paddr,
    input  wire logic [mivu_pkg::DATA_WIDTH-1:0]            pwdata,
    output logic      [mivu_pkg::DATA_WIDTH-1:0]            prdata,
    output logic                                            pready,
    input  wire logic                                       s_axis_tvalid,
    output logic                                            s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                            m_axis_tvalid,
    input  wire logic                                       m_axis_tready,
    // sep_x, sep_y, sep_z, dist_sq, image_x, image_y, image_z
    output logic      [((6*COORD_WIDTH+64+7)/8)*8-1:0]      m_axis_tdata
);

    localparam int unsigned CWD   = COORD_WIDTH;
    localparam int unsigned DW    = COORD_WIDTH + 1;
    localparam int unsigned FLW   = $bits(mivu_pkg::mode_flags_t);
    localparam int unsigned QW    = 3 * CWD + 3 * DW + FLW;
    localparam int unsigned OTW   = ((6*COORD_WIDTH+64+7)/8)*8;

    mivu_pkg::cfg_t        cfg;
    logic                  q_full, q_empty, q_push, q_pop;
    logic [QW-1:0]         q_wdata, q_rdata;
    logic signed [CWD-1:0] f_p1 [3];
    logic signed [DW-1:0]  f_d [3];
    mivu_pkg::mode_flags_t f_flags;
    logic signed [CWD-1:0] b_p1 [3];
    logic signed [DW-1:0]  b_d [3];
    mivu_pkg::mode_flags_t b_flags;
    logic                  b_ready;
    logic signed [CWD-1:0] sep [3];
    logic signed [CWD-1:0] image [3];
    logic [63:0]           dist_sq;

    mivu_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mivu_front #(.COORD_WIDTH(COORD_WIDTH)) u_front
    (
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_coords (s_axis_tdata[6*CWD-1:0]),
        .box_mode  (cfg.box_mode),
        .q_full    (q_full),
        .q_push    (q_push),
        .p1        (f_p1),
        .d         (f_d),
        .flags     (f_flags)
    );

    assign q_wdata = {f_flags, f_d[2], f_d[1], f_d[0], f_p1[2], f_p1[1], f_p1[0]};

    mivu_queue #(.WIDTH(QW), .DEPTH(4)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_p1[i] = q_rdata[i*CWD +: CWD];
            b_d[i]  = q_rdata[3*CWD + i*DW +: DW];
        end
        b_flags = q_rdata[QW-1 -: FLW];
    end

    assign q_pop = b_ready && !q_empty;

    mivu_back #(.COORD_WIDTH(COORD_WIDTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (!q_empty),
        .in_ready  (b_ready),
        .in_p1     (b_p1),
        .in_d      (b_d),
        .in_flags  (b_flags),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sep       (sep),
        .dist_sq   (dist_sq),
        .image     (image)
    );

    assign m_axis_tdata = OTW'({image[2], image[1], image[0], dist_sq,
                                sep[2], sep[1], sep[0]});

endmodule
`default_nettype wire
